// ===== design/rwse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwse_pkg
// Types and constants shared by the run-length word stream expander.
// ----------------------------------------------------------------------------
package rwse_pkg;

  localparam int WORD_W = 16;
  localparam int LEN_W  = 5;
  localparam int REM_W  = 6;

  // Header bit positions within the low byte
  localparam int HDR_ZERO_BIT  = 7;
  localparam int HDR_ONES_BIT  = 6;
  localparam int HDR_DUMMY_BIT = 5;

  localparam logic [WORD_W-1:0] ZERO_VALUE = 16'd0;
  localparam logic [WORD_W-1:0] ONES_VALUE = 16'd255;

  // One run for the back end: a value repeated len_m1 + 1 times
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [LEN_W-1:0]  len_m1;
  } rwse_cmd_t;

endpackage : rwse_pkg
`default_nettype wire

// ===== design/rwse_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwse_front
// Classifies each stream word as a literal or a header; literals and non-dummy
// fill headers become run commands. Tracks the literal run in progress.
// ----------------------------------------------------------------------------
module rwse_front
  import rwse_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic signed [WORD_W-1:0] word_in,
  output rwse_cmd_t                     cmd,
  output logic                          cmd_valid
);

  logic             literal_active;
  logic             literal_active_next;
  logic [REM_W-1:0] literal_remaining;
  logic [REM_W-1:0] literal_remaining_next;
  logic [7:0]       hdr;
  logic             lit_on;

  always_comb begin
    hdr                    = word_in[7:0];
    lit_on                 = literal_active && (literal_remaining != '0);
    literal_active_next    = literal_active;
    literal_remaining_next = literal_remaining;
    cmd_valid              = 1'b0;
    cmd.value              = word_in;
    cmd.len_m1             = '0;
    if (lit_on) begin
      cmd_valid              = 1'b1;
      literal_remaining_next = literal_remaining - REM_W'(1);
      literal_active_next    = (literal_remaining != REM_W'(1));
    end else begin
      // clear a stale flag left with nothing remaining
      literal_active_next = 1'b0;
      if (hdr[HDR_ZERO_BIT]) begin
        cmd_valid  = !hdr[HDR_DUMMY_BIT];
        cmd.value  = ZERO_VALUE;
        cmd.len_m1 = hdr[LEN_W-1:0];
      end else if (hdr[HDR_ONES_BIT]) begin
        cmd_valid  = !hdr[HDR_DUMMY_BIT];
        cmd.value  = ONES_VALUE;
        cmd.len_m1 = hdr[LEN_W-1:0];
      end else if (!hdr[HDR_DUMMY_BIT]) begin
        literal_active_next    = 1'b1;
        literal_remaining_next = {1'b0, hdr[LEN_W-1:0]} + REM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      literal_active    <= 1'b0;
      literal_remaining <= '0;
    end else if (accept) begin
      literal_active    <= literal_active_next;
      literal_remaining <= literal_remaining_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a literal header always opens a run of at least one word
  a_run_opens: assert property (@(posedge clk) disable iff (rst)
    (accept && !lit_on && literal_active_next) |=>
      (literal_remaining != '0 && literal_remaining <= REM_W'(32)))
    else $error("literal run length out of range");

  // a literal word never leaves a nonzero count with the flag down
  a_flag_count: assert property (@(posedge clk) disable iff (rst)
    (accept && lit_on) |=> (literal_active == (literal_remaining != '0)))
    else $error("literal flag and count disagree");
`endif

endmodule : rwse_front
`default_nettype wire

// ===== design/rwse_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwse_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rwse_queue
  import rwse_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  rwse_cmd_t wr_data,
  input  wire logic rd,
  output rwse_cmd_t rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rwse_cmd_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd && empty))
    else $error("command queue underflow");
`endif

endmodule : rwse_queue
`default_nettype wire

// ===== design/rwse_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwse_back
// Expands run commands into samples, one per cycle while not stalled by pop,
// into an output register.
module rwse_back
  import rwse_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  rwse_cmd_t                     q_data,
  input  wire logic                     q_empty,
  output logic                          q_rd,
  output logic signed [WORD_W-1:0]      sample_value,
  output logic                          run_last,
  output logic                          empty,
  input  wire logic                     pop
);

  logic              out_valid;
  logic              out_free;
  logic              cur_active;
  logic [WORD_W-1:0] cur_value;
  logic [LEN_W-1:0]  cur_rem;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign q_rd     = out_free && !cur_active && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cur_active <= 1'b0;
    end else if (out_free) begin
      if (cur_active) begin
        out_valid  <= 1'b1;
        cur_active <= (cur_rem != '0);
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        cur_active <= (q_data.len_m1 != '0);
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cur_active) begin
        sample_value <= cur_value;
        run_last     <= (cur_rem == '0);
        cur_rem      <= cur_rem - LEN_W'(1);
      end else if (!q_empty) begin
        sample_value <= q_data.value;
        run_last     <= (q_data.len_m1 == '0);
        cur_value    <= q_data.value;
        cur_rem      <= q_data.len_m1 - LEN_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // the last sample of a run leaves no run in progress
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_free && cur_active && cur_rem == '0) |=> (!cur_active && run_last))
    else $error("run did not end on its last sample");

  // a held result must not be overwritten by expansion
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(cur_active)))
    else $error("expansion advanced while result stalled");
`endif

endmodule : rwse_back
`default_nettype wire

// ===== design/rle_word_stream_expander_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_word_stream_expander_core
// Run-length word stream expander: fill headers become runs of 0 or 255,
// literal runs pass through word for word.
// ----------------------------------------------------------------------------
// An accepted item is written into the command queue, then loaded into the
// output register, from which it can be taken with pop.
// Throughput: literals 1 per cycle while the queue has room; a fill header
// gives N samples from the output register, one per cycle while pop keeps up.
// Input is taken while the command queue (QUEUE_DEPTH runs) has room.
// Reset: synchronous rst clears the literal state, the queue and output valid.
// ----------------------------------------------------------------------------
module rle_word_stream_expander_core
  import rwse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [WORD_W-1:0] word_in,
  output logic                          empty,
  input  wire logic                     pop,
  output logic signed [WORD_W-1:0]      sample_value,
  output logic                          run_last
);

  rwse_cmd_t fe_cmd;
  logic      fe_cmd_valid;
  logic      accept;
  rwse_cmd_t q_data;
  logic      q_empty;
  logic      q_rd;

  assign accept = push && !full;

  rwse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .word_in   (word_in),
    .cmd       (fe_cmd),
    .cmd_valid (fe_cmd_valid)
  );

  rwse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && fe_cmd_valid),
    .wr_data (fe_cmd),
    .rd      (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  rwse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .sample_value (sample_value),
    .run_last     (run_last),
    .empty        (empty),
    .pop          (pop)
  );

endmodule : rle_word_stream_expander_core
`default_nettype wire
